// ----- hw/rtl/sea_pkg.sv -----
// Shared types and constants for the SeaHash stream hash block.
`timescale 1ns / 1ps
`default_nettype none
package sea_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned WordBytes = 8;

  localparam logic [WordW-1:0] SEA_MUL = 64'h6eed0e9da4d94a4f;
  localparam logic [WordW-1:0] SEA_INIT_A = 64'h16f11fe89b0d677c;
  localparam logic [WordW-1:0] SEA_INIT_B = 64'hb480a793d8e6c86c;
  localparam logic [WordW-1:0] SEA_INIT_C = 64'h6fe2e5aaf078ebc9;
  localparam logic [WordW-1:0] SEA_INIT_D = 64'h14f994a4c5259381;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MA_LO,
    S_MA_X1,
    S_MA_X2,
    S_XSHIFT,
    S_MB_LO,
    S_MB_X1,
    S_MB_X2,
    S_ROTATE,
    S_FINAL_LOAD,
    S_OUTPUT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ABSORB_LOAD,
    OP_FINAL_LOAD,
    OP_MUL_LO,
    OP_MUL_X1,
    OP_MUL_X2,
    OP_SHIFT,
    OP_ROTATE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic absorb_needed;
    logic in_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/seahash_stream_hash.sv -----
// Top level of the SeaHash stream hash block.
//
// Channel  Direction  Handshake              Beat payload
// in       input      in_valid / in_ready    data_word[63:0], byte_count[3:0], last
// out      output     out_valid / out_ready  digest[63:0]
//
// One beat is processed at a time. A word beat is loaded, then mixed through one shared 32x32
// multiplier (three passes per 64-bit product plus the shift-xor) and ends with one lane rotate
// before the next beat can be taken. A last beat then goes on to a final load and a second mix
// for the digest; a last beat with no bytes does only that final load and mix.
// Reset puts the lanes at their initial values and clears the length and output valid.
// A digest waiting in the output register stalls only the next digest, not absorbing.
`timescale 1ns / 1ps
`default_nettype none
module seahash_stream_hash
  import sea_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WordW-1:0]  data_word,
  input  wire logic [CountW-1:0] byte_count,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WordW-1:0]       digest
);

  dp_cmd_t    cmd;
  dp_status_t status;

  sea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sea_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .digest     (digest)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a beat is still being processed");

  a_no_digest_mid_message: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last) |=> !$rose(out_valid))
    else $error("digest raised right after a beat that is not last");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/sea_datapath.sv -----
// Datapath: lanes, length counter, shared 32x32 multiplier, mixing and digest register.
`timescale 1ns / 1ps
`default_nettype none
module sea_datapath
  import sea_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output dp_status_t             status,
  input  wire logic [WordW-1:0]  data_word,
  input  wire logic [CountW-1:0] byte_count,
  input  wire logic              last,
  output logic [WordW-1:0]       digest
);

  logic [WordW-1:0] lane_a;
  logic [WordW-1:0] lane_b;
  logic [WordW-1:0] lane_c;
  logic [WordW-1:0] lane_d;
  logic [WordW-1:0] total_bytes;
  logic [WordW-1:0] x;
  logic [WordW-1:0] acc;

  logic [CountW-1:0] cnt_eff;
  logic [WordW-1:0]  masked_word;
  logic [HalfW-1:0]  mul_a;
  logic [HalfW-1:0]  mul_b;
  logic [WordW-1:0]  prod;
  logic [HalfW-1:0]  acc_hi_sum;
  logic [HalfW-1:0]  xs_term;

  always_comb begin
    if (!last || (byte_count > CountW'(WordBytes))) begin
      cnt_eff = CountW'(WordBytes);
    end else begin
      cnt_eff = byte_count;
    end
    for (int i = 0; i < WordBytes; i++) begin
      masked_word[i*8 +: 8] = (CountW'(i) < cnt_eff) ? data_word[i*8 +: 8] : 8'h00;
    end
  end

  assign status.absorb_needed = (cnt_eff != '0);
  assign status.in_last = last;

  assign mul_a = (cmd.op == OP_MUL_X2) ? x[WordW-1:HalfW] : x[HalfW-1:0];
  assign mul_b = (cmd.op == OP_MUL_X1) ? SEA_MUL[WordW-1:HalfW] : SEA_MUL[HalfW-1:0];
  assign prod = mul_a * mul_b;
  assign acc_hi_sum = acc[WordW-1:HalfW] + prod[HalfW-1:0];
  assign xs_term = x[WordW-1:HalfW] >> x[WordW-1:WordW-4];

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_a <= SEA_INIT_A;
      lane_b <= SEA_INIT_B;
      lane_c <= SEA_INIT_C;
      lane_d <= SEA_INIT_D;
      total_bytes <= '0;
    end else begin
      case (cmd.op)
        OP_ABSORB_LOAD: begin
          total_bytes <= total_bytes + WordW'(cnt_eff);
        end
        OP_ROTATE: begin
          lane_a <= lane_b;
          lane_b <= lane_c;
          lane_c <= lane_d;
          lane_d <= x;
        end
        OP_EMIT: begin
          lane_a <= SEA_INIT_A;
          lane_b <= SEA_INIT_B;
          lane_c <= SEA_INIT_C;
          lane_d <= SEA_INIT_D;
          total_bytes <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ABSORB_LOAD: x <= lane_a ^ masked_word;
      OP_FINAL_LOAD:  x <= lane_a ^ lane_b ^ lane_c ^ lane_d ^ total_bytes;
      OP_MUL_LO:      acc <= prod;
      OP_MUL_X1:      acc[WordW-1:HalfW] <= acc_hi_sum;
      OP_MUL_X2:      x <= {acc_hi_sum, acc[HalfW-1:0]};
      OP_SHIFT:       x <= x ^ {{HalfW{1'b0}}, xs_term};
      OP_EMIT:        digest <= x;
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sea_ctrl.sv -----
// Controller state machine that sequences absorb, mixing and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sea_ctrl
  import sea_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        last_flag;
  logic        final_phase;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (in_valid) state_next = S_MA_LO;
      S_MA_LO:      state_next = S_MA_X1;
      S_MA_X1:      state_next = S_MA_X2;
      S_MA_X2:      state_next = S_XSHIFT;
      S_XSHIFT:     state_next = S_MB_LO;
      S_MB_LO:      state_next = S_MB_X1;
      S_MB_X1:      state_next = S_MB_X2;
      S_MB_X2:      state_next = final_phase ? S_OUTPUT : S_ROTATE;
      S_ROTATE:     state_next = last_flag ? S_FINAL_LOAD : S_IDLE;
      S_FINAL_LOAD: state_next = S_MA_LO;
      S_OUTPUT:     if (!out_valid || out_ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = status.absorb_needed ? OP_ABSORB_LOAD : OP_FINAL_LOAD;
        end
      end
      S_MA_LO, S_MB_LO: cmd.op = OP_MUL_LO;
      S_MA_X1, S_MB_X1: cmd.op = OP_MUL_X1;
      S_MA_X2, S_MB_X2: cmd.op = OP_MUL_X2;
      S_XSHIFT:         cmd.op = OP_SHIFT;
      S_ROTATE:         cmd.op = OP_ROTATE;
      S_FINAL_LOAD:     cmd.op = OP_FINAL_LOAD;
      S_OUTPUT: begin
        if (!out_valid || out_ready) begin
          cmd.op = OP_EMIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last_flag <= 1'b0;
      final_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        last_flag <= status.in_last;
        final_phase <= !status.absorb_needed;
      end else if (state == S_FINAL_LOAD) begin
        final_phase <= 1'b1;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
